/* src/bis_pkg.sv */
// shared types, constants and codes for the bencode integer and string scanner
package bis_pkg;

  // width of the string length counter
  localparam int LEN_BITS = 32;

  // depth of the queue between the classifier and the parser
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // largest length, integer magnitude limits
  localparam logic [63:0] LEN_MASK    = {64{1'b1}} >> (64 - LEN_BITS);
  localparam logic [63:0] INT_POS_LIM = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] INT_NEG_LIM = 64'h8000_0000_0000_0000;

  // special characters of the stream
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result kinds
  localparam logic [1:0] KIND_INT   = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_LEAD      = 3'd1;
  localparam logic [2:0] ERR_INT_CHAR  = 3'd2;
  localparam logic [2:0] ERR_NO_DIGITS = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;
  localparam logic [2:0] ERR_LEN_CHAR  = 3'd5;

  // parser modes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_INT_START,
    MODE_INT_DIGITS,
    MODE_LEN,
    MODE_PAYLOAD
  } mode_t;

  // byte classes found by the front end
  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_I,
    CLS_E,
    CLS_COLON,
    CLS_MINUS,
    CLS_OTHER
  } cls_t;

  // one classified byte as it sits in the queue
  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic [7:0] data;
  } q_entry_t;

endpackage

/* src/bis_in_if.sv */
// byte input channel of the scanner
interface bis_in_if
  import bis_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* src/bis_out_if.sv */
// result channel of the scanner
interface bis_out_if
  import bis_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [63:0] int_value;
  logic [7:0]         data_byte;
  logic               last_of_string;
  logic [2:0]         error_code;

  modport source (output valid, output result_kind, output int_value, output data_byte,
                  output last_of_string, output error_code, input ready);
  modport sink   (input valid, input result_kind, input int_value, input data_byte,
                  input last_of_string, input error_code, output ready);
endinterface

/* src/bis_front.sv */
// front end: accepts raw bytes, classifies them and pushes them into the queue
module bis_front
  import bis_pkg::*;
(
  bis_in_if.sink    in_ch,
  input  logic      q_full,
  output logic      q_push,
  output q_entry_t  push_entry
);

  logic is_digit;

  // digit detection
  assign is_digit = (in_ch.in_byte >= CH_ZERO) && (in_ch.in_byte <= CH_NINE);

  // byte classification
  always_comb begin
    push_entry.data  = in_ch.in_byte;
    push_entry.digit = is_digit ? 4'(in_ch.in_byte - CH_ZERO) : 4'd0;
    if (is_digit) begin
      push_entry.cls = CLS_DIGIT;
    end else if (in_ch.in_byte == CH_I) begin
      push_entry.cls = CLS_I;
    end else if (in_ch.in_byte == CH_E) begin
      push_entry.cls = CLS_E;
    end else if (in_ch.in_byte == CH_COLON) begin
      push_entry.cls = CLS_COLON;
    end else if (in_ch.in_byte == CH_MINUS) begin
      push_entry.cls = CLS_MINUS;
    end else begin
      push_entry.cls = CLS_OTHER;
    end
  end

  // transfer whenever the queue has room
  assign in_ch.ready = ~q_full;
  assign q_push      = in_ch.valid & ~q_full;

endmodule

/* src/bis_queue.sv */
// short register queue between the classifier and the parser
module bis_queue
  import bis_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t          slot_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == Q_CW'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rd_ptr_r];

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + Q_CW'(push) - Q_CW'(pop);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* src/bis_back.sv */
// back end: parse state machine, decimal accumulator and result register
module bis_back
  import bis_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  q_head,
  output logic      q_pop,
  bis_out_if.source out_ch
);

  mode_t               mode_r, mode_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic                seen_r, seen_nxt;
  logic [LEN_BITS-1:0] left_r, left_nxt;
  logic [LEN_BITS-1:0] left_dec;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          kind_r;
  logic [63:0]         value_r;
  logic [7:0]          data_r;
  logic                last_r;
  logic [2:0]          err_r;

  logic                take;
  logic                clr;
  logic                res;
  logic [1:0]          res_kind;
  logic [63:0]         res_value;
  logic [7:0]          res_data;
  logic                res_last;
  logic [2:0]          res_err;
  logic [67:0]         prod;
  logic [63:0]         lim;
  logic                ovf;

  // take a queued byte when the result register is free or draining
  assign take  = q_valid & (~out_valid_r | out_ch.ready);
  assign q_pop = take;

  // acc * 10 + digit and the range check against the current limit
  assign prod = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + 68'(q_head.digit);
  always_comb begin
    if (mode_r == MODE_LEN) begin
      lim = LEN_MASK;
    end else if (neg_r) begin
      lim = INT_NEG_LIM;
    end else begin
      lim = INT_POS_LIM;
    end
  end
  assign ovf      = prod > {4'd0, lim};
  assign left_dec = left_r - 1'b1;

  // next state and result
  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    left_nxt  = left_r;
    clr       = 1'b0;
    res       = 1'b0;
    res_kind  = KIND_INT;
    res_value = '0;
    res_data  = '0;
    res_last  = 1'b0;
    res_err   = ERR_NONE;
    if (take) begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (q_head.cls == CLS_I) begin
            clr      = 1'b1;
            mode_nxt = MODE_INT_START;
          end else if (q_head.cls == CLS_DIGIT) begin
            acc_nxt  = {60'd0, q_head.digit};
            seen_nxt = 1'b1;
            neg_nxt  = 1'b0;
            left_nxt = '0;
            mode_nxt = MODE_LEN;
          end else begin
            res      = 1'b1;
            res_kind = KIND_ERROR;
            res_err  = ERR_LEAD;
          end
        end
        MODE_INT_START, MODE_INT_DIGITS: begin
          if (q_head.cls == CLS_MINUS && mode_r == MODE_INT_START) begin
            neg_nxt  = 1'b1;
            mode_nxt = MODE_INT_DIGITS;
          end else if (q_head.cls == CLS_DIGIT) begin
            if (ovf) begin
              res      = 1'b1;
              res_kind = KIND_ERROR;
              res_err  = ERR_OVERFLOW;
            end else begin
              acc_nxt  = prod[63:0];
              seen_nxt = 1'b1;
              mode_nxt = MODE_INT_DIGITS;
            end
          end else if (q_head.cls == CLS_E) begin
            res = 1'b1;
            if (!seen_r) begin
              res_kind = KIND_ERROR;
              res_err  = ERR_NO_DIGITS;
            end else begin
              res_kind  = KIND_INT;
              res_value = neg_r ? (64'd0 - acc_r) : acc_r;
              clr       = 1'b1;
              mode_nxt  = MODE_IDLE;
            end
          end else begin
            res      = 1'b1;
            res_kind = KIND_ERROR;
            res_err  = ERR_INT_CHAR;
          end
        end
        MODE_LEN: begin
          if (q_head.cls == CLS_DIGIT) begin
            if (ovf) begin
              res      = 1'b1;
              res_kind = KIND_ERROR;
              res_err  = ERR_OVERFLOW;
            end else begin
              acc_nxt = prod[63:0];
            end
          end else if (q_head.cls == CLS_COLON) begin
            if (acc_r == '0) begin
              res      = 1'b1;
              res_kind = KIND_EMPTY;
              clr      = 1'b1;
              mode_nxt = MODE_IDLE;
            end else begin
              left_nxt = acc_r[LEN_BITS-1:0];
              acc_nxt  = '0;
              mode_nxt = MODE_PAYLOAD;
            end
          end else begin
            res      = 1'b1;
            res_kind = KIND_ERROR;
            res_err  = ERR_LEN_CHAR;
          end
        end
        MODE_PAYLOAD: begin
          left_nxt = left_dec;
          res      = 1'b1;
          res_kind = KIND_BYTE;
          res_data = q_head.data;
          res_last = (left_dec == '0);
          if (left_dec == '0) begin
            clr      = 1'b1;
            mode_nxt = MODE_IDLE;
          end
        end
        default: begin
          clr      = 1'b1;
          mode_nxt = MODE_IDLE;
        end
      endcase
      // every error drops back to idle
      if (res && res_kind == KIND_ERROR) begin
        clr      = 1'b1;
        mode_nxt = MODE_IDLE;
      end
      if (clr) begin
        acc_nxt  = '0;
        neg_nxt  = 1'b0;
        seen_nxt = 1'b0;
        left_nxt = '0;
      end
    end
  end

  // result register occupancy
  always_comb begin
    if (take) begin
      out_valid_nxt = res;
    end else begin
      out_valid_nxt = out_valid_r & ~out_ch.ready;
    end
  end

  // state machine and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      seen_r      <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      seen_r      <= seen_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && res) begin
      kind_r  <= res_kind;
      value_r <= res_value;
      data_r  <= res_data;
      last_r  <= res_last;
      err_r   <= res_err;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = kind_r;
  assign out_ch.int_value      = value_r;
  assign out_ch.data_byte      = data_r;
  assign out_ch.last_of_string = last_r;
  assign out_ch.error_code     = err_r;

endmodule

/* src/bencode_int_string_scanner.sv */
// top level of the bencode integer and byte-string scanner
// Takes one byte per transfer and sustains one byte per clock cycle while the
// output is not stalled: each byte costs a single pass through the parser's
// multiply-by-ten-and-add accumulator, which is the loop that sets the rate. A
// classified byte waits in a two-entry queue, and a result is registered in the
// output register as its last byte is taken from the queue. Integers give
// one result on the closing 'e', each string payload byte gives one result (the
// last one marked), "0:" gives one empty-string result and every malformed byte
// gives one error result, after which parsing starts again in idle with the
// next byte. Lengths are LEN_BITS wide.
module bencode_int_string_scanner
  import bis_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bis_in_if.sink    in_ch,
  bis_out_if.source out_ch
);

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  q_entry_t push_entry;
  q_entry_t q_head;

  // classifier
  bis_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .q_push     (q_push),
    .push_entry (push_entry)
  );

  // decoupling queue
  bis_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // parser and result register
  bis_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* src/bis_checker.sv */
// port-level checks for the scanner, bound to the top level
module bis_checker
  import bis_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [63:0] int_value,
  input logic [7:0]  data_byte,
  input logic        last_of_string,
  input logic [2:0]  error_code
);

  // result channel is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // error code only on error results, and then a real code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((result_kind == KIND_ERROR) ?
      (error_code == ERR_LEAD || error_code == ERR_INT_CHAR ||
       error_code == ERR_NO_DIGITS || error_code == ERR_OVERFLOW ||
       error_code == ERR_LEN_CHAR) :
      (error_code == ERR_NONE)))
    else $error("error code inconsistent with result kind");

  // unused fields are zero
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((result_kind == KIND_INT || int_value == '0) &&
      (result_kind == KIND_BYTE || (data_byte == '0 && !last_of_string))))
    else $error("stray payload on result");

endmodule

bind bencode_int_string_scanner bis_checker u_bis_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .result_kind    (out_ch.result_kind),
  .int_value      (out_ch.int_value),
  .data_byte      (out_ch.data_byte),
  .last_of_string (out_ch.last_of_string),
  .error_code     (out_ch.error_code)
);

/* tb/bis_scoreboard_pkg.sv */
// scoreboard class that predicts and checks the scanner's results
package bis_scoreboard_pkg;
  import bis_pkg::*;

  // one result as seen on the output channel
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [63:0] value;
    logic [7:0]         data;
    logic               last;
    logic [2:0]         err;
  } scan_result_t;

  class bencode_scoreboard;
    // mirror of the parser state
    mode_t       mode;
    logic [63:0] acc;
    logic        neg;
    logic        seen;
    logic [63:0] left;

    scan_result_t pending_results[$];
    int           failures;

    function new();
      clear_state();
      failures = 0;
    endfunction

    function void clear_state();
      mode = MODE_IDLE;
      acc  = '0;
      neg  = 1'b0;
      seen = 1'b0;
      left = '0;
    endfunction

    // an error result always sends the parser back to idle
    function scan_result_t fault(logic [2:0] code);
      scan_result_t r;
      r      = '0;
      r.kind = KIND_ERROR;
      r.err  = code;
      clear_state();
      return r;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // advance the mirror by one accepted byte and queue the result it causes
    function void note_byte(logic [7:0] b);
      logic        is_dig;
      logic [63:0] d;
      logic [63:0] lim;
      scan_result_t r;
      bit          got;
      is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
      d      = is_dig ? 64'(b - CH_ZERO) : 64'd0;
      r      = '0;
      got    = 1'b0;
      case (mode)
        MODE_IDLE: begin
          if (b == CH_I) begin
            clear_state();
            mode = MODE_INT_START;
          end else if (is_dig) begin
            clear_state();
            acc  = d;
            seen = 1'b1;
            mode = MODE_LEN;
          end else begin
            r   = fault(ERR_LEAD);
            got = 1'b1;
          end
        end
        MODE_INT_START, MODE_INT_DIGITS: begin
          if (b == CH_MINUS && mode == MODE_INT_START) begin
            neg  = 1'b1;
            mode = MODE_INT_DIGITS;
          end else if (is_dig) begin
            lim  = neg ? INT_NEG_LIM : INT_POS_LIM;
            mode = MODE_INT_DIGITS;
            if (acc > (lim - d) / 10) begin
              r   = fault(ERR_OVERFLOW);
              got = 1'b1;
            end else begin
              acc  = acc * 10 + d;
              seen = 1'b1;
            end
          end else if (b == CH_E) begin
            got = 1'b1;
            if (!seen) begin
              r = fault(ERR_NO_DIGITS);
            end else begin
              r.kind  = KIND_INT;
              r.value = neg ? -acc : acc;
              clear_state();
            end
          end else begin
            r   = fault(ERR_INT_CHAR);
            got = 1'b1;
          end
        end
        MODE_LEN: begin
          if (is_dig) begin
            if (acc > (LEN_MASK - d) / 10) begin
              r   = fault(ERR_OVERFLOW);
              got = 1'b1;
            end else begin
              acc = acc * 10 + d;
            end
          end else if (b == CH_COLON) begin
            if (acc == 0) begin
              r.kind = KIND_EMPTY;
              got    = 1'b1;
              clear_state();
            end else begin
              left = acc & LEN_MASK;
              acc  = '0;
              mode = MODE_PAYLOAD;
            end
          end else begin
            r   = fault(ERR_LEN_CHAR);
            got = 1'b1;
          end
        end
        MODE_PAYLOAD: begin
          left   = (left - 1) & LEN_MASK;
          r.kind = KIND_BYTE;
          r.data = b;
          r.last = (left == 0);
          got    = 1'b1;
          if (r.last) clear_state();
        end
        default: clear_state();
      endcase
      if (got) pending_results.push_back(r);
    endfunction

    // compare one output transfer with the oldest expected result
    function void check_result(scan_result_t act);
      scan_result_t exp;
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_kind %0d", act.kind);
        failures++;
        return;
      end
      exp = pending_results.pop_front();
      if (act.kind !== exp.kind) begin
        $error("result_kind: expected %0d, actual %0d", exp.kind, act.kind);
        failures++;
      end
      if (act.value !== exp.value) begin
        $error("int_value: expected %0d, actual %0d", exp.value, act.value);
        failures++;
      end
      if (act.data !== exp.data) begin
        $error("data_byte: expected 0x%02h, actual 0x%02h", exp.data, act.data);
        failures++;
      end
      if (act.last !== exp.last) begin
        $error("last_of_string: expected %0d, actual %0d", exp.last, act.last);
        failures++;
      end
      if (act.err !== exp.err) begin
        $error("error_code: expected %0d, actual %0d", exp.err, act.err);
        failures++;
      end
    endfunction
  endclass

endpackage

/* tb/testbench.sv */
// top-level testbench for the bencode integer and string scanner
module testbench;
  import bis_pkg::*;
  import bis_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  localparam int ITEM_COUNT  = 1950;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 20;

  // hand-picked opening stream: bad lead, "ie", "i--", "i5a", "1:\xff", "0:",
  // "2a", "i-0e", "i7e"
  localparam logic [7:0] DIRECTED_BYTES [0:22] = '{
    "Z", CH_I, CH_E, CH_I, CH_MINUS, CH_MINUS, CH_I, "5", "a",
    "1", CH_COLON, 8'hff, "0", CH_COLON, "2", "a",
    CH_I, CH_MINUS, "0", CH_E, CH_I, "7", CH_E
  };

  logic clk;
  logic rst_n;

  bis_in_if  in_ch();
  bis_out_if out_ch();

  bencode_int_string_scanner uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bencode_scoreboard sb = new();

  int in_run_left  = 0;
  bit in_quiet     = 0;
  int out_run_left = 0;
  bit out_quiet    = 0;
  int bytes_sent   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // known values on every input from time zero
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    out_ch.ready   = 1'b0;
  end

  // per-item wait, randomly chosen stretches of back-to-back transfers or random gaps
  function automatic int next_gap(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      quiet    = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(10, 60);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // decimal text of a value, with optional leading zeros
  function automatic void push_decimal(ref byte_q_t q, input logic [63:0] v, input int zeros);
    byte_q_t     digs;
    logic [63:0] t;
    t = v;
    repeat (zeros) q.push_back(CH_ZERO);
    do begin
      digs.push_front(CH_ZERO + 8'(t % 10));
      t = t / 10;
    end while (t != 0);
    foreach (digs[k]) q.push_back(digs[k]);
  endfunction

  // any byte that is not a digit and not the given terminator
  function automatic logic [7:0] bad_char(logic [7:0] term);
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0 && term != CH_MINUS) return CH_MINUS;
    do b = 8'($urandom); while ((b >= CH_ZERO && b <= CH_NINE) || b == term);
    return b;
  endfunction

  // one top-level element, mostly well formed, sometimes broken or noise
  function automatic void build_element(ref byte_q_t q);
    int          pick;
    int          len;
    int          zeros;
    logic        neg;
    logic [63:0] mag;
    q.delete();
    pick  = $urandom_range(0, 99);
    zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    if (pick < 35) begin
      // well-formed integer, extremes now and then
      neg = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0, 1:    mag = 64'($urandom_range(0, 99));
        2, 3:    mag = {1'b0, 31'($urandom), 32'($urandom)} >> $urandom_range(0, 62);
        4:       mag = {1'b0, 31'($urandom), 32'($urandom)};
        default: mag = neg ? INT_NEG_LIM : INT_POS_LIM;
      endcase
      q.push_back(CH_I);
      if (neg) q.push_back(CH_MINUS);
      push_decimal(q, mag, zeros);
      q.push_back(CH_E);
    end else if (pick < 70) begin
      // well-formed string with random payload
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = $urandom_range(9, 40);
        default: len = $urandom_range(1, 8);
      endcase
      push_decimal(q, 64'(len), zeros);
      q.push_back(CH_COLON);
      repeat (len) q.push_back(8'($urandom));
    end else if (pick < 78) begin
      // integer magnitude just past its limit
      neg = 1'($urandom_range(0, 1));
      mag = (neg ? INT_NEG_LIM : INT_POS_LIM) + 64'($urandom_range(1, 1000));
      q.push_back(CH_I);
      if (neg) q.push_back(CH_MINUS);
      push_decimal(q, mag, 0);
      q.push_back(CH_E);
    end else if (pick < 84) begin
      // length just past its limit
      push_decimal(q, LEN_MASK + 64'($urandom_range(1, 1000)), zeros);
      q.push_back(CH_COLON);
    end else if (pick < 92) begin
      // integer cut short by a stray byte, or closed after zero to three digits
      q.push_back(CH_I);
      if ($urandom_range(0, 1)) q.push_back(CH_MINUS);
      repeat ($urandom_range(0, 3)) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      q.push_back(($urandom_range(0, 3) == 0) ? CH_E : bad_char(CH_E));
    end else if (pick < 96) begin
      // length prefix with a stray byte
      repeat ($urandom_range(1, 3)) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      q.push_back(bad_char(CH_COLON));
    end else begin
      // lone byte that cannot start an element
      q.push_back(bad_char(CH_I));
    end
  endfunction

  // offer one byte and wait for its transfer
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = next_gap(in_run_left, in_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin : result_sink
    int           gap;
    scan_result_t act;
    wait (rst_n === 1'b1);
    forever begin
      gap = (results_seen == 150) ? LONG_HOLD : next_gap(out_run_left, out_quiet);
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      act.kind  = out_ch.result_kind;
      act.value = out_ch.int_value;
      act.data  = out_ch.data_byte;
      act.last  = out_ch.last_of_string;
      act.err   = out_ch.error_code;
      sb.check_result(act);
      results_seen++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, stimulus and end of run
  initial begin : stimulus
    byte_q_t elem;
    bit      paused;
    paused = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_BYTES[k]) send_byte(DIRECTED_BYTES[k]);

    while (bytes_sent < ITEM_COUNT) begin
      build_element(elem);
      foreach (elem[k]) send_byte(elem[k]);
      // one pause at an element boundary until the output side has caught up
      if (!paused && bytes_sent >= ITEM_COUNT / 2) begin
        paused = 1'b1;
        stop_sending();
        while (sb.pending() != 0) @(posedge clk);
      end
    end
    stop_sending();

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/bis_pkg.sv
src/bis_in_if.sv
src/bis_out_if.sv
src/bis_front.sv
src/bis_queue.sv
src/bis_back.sv
src/bencode_int_string_scanner.sv
src/bis_checker.sv
tb/bis_scoreboard_pkg.sv
tb/testbench.sv
